// File: design/bcr_pkg.sv
// Shared types and constants for the bitstream code reader.
package bcr_pkg;

  localparam int unsigned QueueDepthDefault = 16;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_RAW     = 3'd1,
    OP_GAMMA   = 3'd2,
    OP_FGAMMA  = 3'd3,
    OP_OFFSET  = 3'd4,
    OP_LENGTH  = 3'd5,
    OP_FLUFF   = 3'd6,
    OP_RESTART = 3'd7
  } op_e;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusInvalid   = 2'd1;
  localparam logic [1:0] StatusUnderflow = 2'd2;

  localparam logic [31:0] OffsetBias    = 32'd248;
  localparam logic [31:0] OffsetBigBase = 32'd8322816;
  localparam logic [31:0] LengthBias    = 32'd64;

  // Leading zeros of a 32-bit word (32 for zero).
  function automatic logic [5:0] lzc32(input logic [31:0] w);
    logic [5:0] n;
    logic       found;
    n = 6'd32;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found && w[i]) begin
        n = 6'(31 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// File: design/bcr_queue.sv
// Byte queue holding stream bytes until the window refill takes them.
module bcr_queue #(
  parameter int unsigned QueueDepth = bcr_pkg::QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       clear_i,
  input  logic       push_i,
  input  logic [7:0] push_data_i,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] head_data_o
);
  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [7:0]      mem_q [QueueDepth];
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail;
  logic [CntW-1:0] count_q, count_d;
  logic            full;
  logic [IdxW:0]   tail_sum;
  logic            wr_en;
  logic [7:0]      rd_data_q;

  assign full     = (count_q == CntW'(QueueDepth));
  assign empty_o  = (count_q == '0);
  assign tail_sum = (IdxW+1)'(head_q) + (IdxW+1)'(count_q);
  assign tail     = (tail_sum >= (IdxW+1)'(QueueDepth)) ?
                    IdxW'(tail_sum - (IdxW+1)'(QueueDepth)) : IdxW'(tail_sum);
  assign wr_en    = push_i && !full && !clear_i;
  assign head_data_o = rd_data_q;

  // Advance head and count on pop and push.
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (clear_i) begin
      head_d  = '0;
      count_d = '0;
    end else begin
      if (pop_i && !empty_o) begin
        head_d  = (head_q == IdxW'(QueueDepth - 1)) ? '0 : head_q + 1'b1;
        count_d = count_d - 1'b1;
      end
      if (push_i && !full) begin
        count_d = count_d + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Store pushed bytes; drop them when full. Register the byte at the next
  // head, forwarding a byte written to that same slot.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[tail] <= push_data_i;
    end
    if (wr_en && (tail == head_d)) begin
      rd_data_q <= push_data_i;
    end else begin
      rd_data_q <= mem_q[head_d];
    end
  end

endmodule

// File: design/bitstream_code_reader.sv
// Top level of the bitstream code reader: window, sequencer and result register.
// Steps: a push or restart is done in the idle state; a read refills the window
// byte by byte, then passes through the fill exit, decode, take and result
// steps; a rejected argument goes straight to the result step.
// Throughput: one request at a time; ready stays low while a read is at work,
// and a read whose result finds the previous one still waiting holds at its end.
// Reset: window empty, queue empty, end flag clear, no result pending.
module bitstream_code_reader #(
  parameter int unsigned QueueDepth = bcr_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [8:0]  argument_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_o,
  output logic [1:0]  status_o
);
  import bcr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FILL, S_DECODE, S_TAKE, S_DONE
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] win_q, win_d;
  logic signed [6:0] def_q, def_d;
  logic        end_q, end_d;
  logic        starve_q, starve_d;
  logic [2:0]  op_q, op_d;
  logic [8:0]  arg_q, arg_d;
  logic [31:0] acc_q, acc_d;
  logic [1:0]  phase_q, phase_d;
  logic [5:0]  lz_q, lz_d;
  logic [31:0] val_q, val_d;
  logic [1:0]  stat_q, stat_d;
  logic        oval_q, oval_d;
  logic [31:0] rval_q, rval_d;
  logic [1:0]  rstat_q, rstat_d;

  logic        q_empty, q_pop, q_push, q_clear;
  logic [7:0]  q_data;
  logic        accept;

  // Shared take unit: remove tk_n bits from the top of the window.
  logic [5:0]  tk_n;
  logic [31:0] tk_val, tk_win;
  always_comb begin
    if (tk_n == 6'd0) begin
      tk_val = '0;
      tk_win = win_q;
    end else if (tk_n >= 6'd32) begin
      tk_val = win_q;
      tk_win = '0;
    end else begin
      tk_val = win_q >> (6'd32 - tk_n);
      tk_win = win_q << tk_n;
    end
  end

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign q_push     = accept && (op_e'(operation_i) == OP_PUSH);
  assign q_clear    = accept && (op_e'(operation_i) == OP_RESTART);
  assign q_pop      = (state_q == S_FILL) && (def_q > 7'sd0) && (def_q < 7'sd32);

  bcr_queue #(.QueueDepth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .clear_i(q_clear),
    .push_i(q_push),
    .push_data_i(data_byte_i),
    .pop_i(q_pop),
    .empty_o(q_empty),
    .head_data_o(q_data)
  );

  logic [5:0]  lz_w;
  logic [5:0]  n_off;
  logic [31:0] fx, fx1;
  logic [5:0]  fy;
  logic [31:0] fz, fv;
  logic [8:0]  fxa;
  assign lz_w = lzc32(win_q);
  assign n_off = (arg_q < 9'h0F0) ? 6'(arg_q[7:4]) + 6'd4 : 6'(arg_q - 9'h0F0) + 6'd4;
  assign fxa  = ((9'd257 - arg_q) > arg_q) ? arg_q : 9'd257 - arg_q;
  assign fx   = {22'd0, fxa, 1'b0};
  assign fx1  = fx - 32'd1;
  assign fy   = 6'd32 - lzc32(fx1);
  assign fz   = (32'd1 << fy) - fx;
  assign fv   = (fy == 6'd0) ? 32'd0 : win_q >> (6'd32 - fy);

  // Sequencer: refill byte by byte, then decode through the take unit.
  always_comb begin
    state_d = state_q; win_d = win_q; def_d = def_q; end_d = end_q;
    starve_d = starve_q; op_d = op_q; arg_d = arg_q; acc_d = acc_q;
    phase_d = phase_q; lz_d = lz_q; val_d = val_q; stat_d = stat_q;
    oval_d = oval_q; rval_d = rval_q; rstat_d = rstat_q; tk_n = 6'd0;
    if (oval_q && out_ready_i) oval_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d = operation_i; arg_d = argument_i;
          unique case (op_e'(operation_i))
            OP_PUSH: if (last_byte_i) end_d = 1'b1;
            OP_RESTART: begin
              win_d = '0; def_d = 7'sd24; end_d = 1'b0;
            end
            default: begin
              starve_d = 1'b0; phase_d = '0; acc_d = '0;
              if ((op_e'(operation_i) == OP_RAW && argument_i > 9'd32) ||
                  (op_e'(operation_i) == OP_OFFSET && argument_i > 9'd255) ||
                  (op_e'(operation_i) == OP_FLUFF &&
                   (argument_i == 9'd0 || argument_i > 9'd256))) begin
                val_d = '0; stat_d = StatusInvalid; state_d = S_DONE;
              end else begin
                state_d = S_FILL;
              end
            end
          endcase
        end
      end
      S_FILL: begin
        if (q_pop) begin
          if (q_empty) begin
            if (!end_q) starve_d = 1'b1;
          end else begin
            win_d = win_q | ({24'd0, q_data} << def_q[4:0]);
          end
          def_d = def_q - 7'sd8;
        end else begin
          state_d = (phase_q == 2'd0) ? S_DECODE : S_TAKE;
        end
      end
      S_DECODE: begin
        lz_d = lz_w;
        stat_d = starve_q ? StatusUnderflow : StatusOk;
        state_d = S_TAKE;
        unique case (op_e'(op_q)) inside
          OP_GAMMA, OP_FGAMMA, OP_LENGTH: begin
            if (win_q == '0 ||
                (op_e'(op_q) == OP_GAMMA && ({lz_w, 1'b0} + 7'd2) > 7'd23) ||
                (op_e'(op_q) == OP_FGAMMA && (10'(lz_w) + 10'(arg_q) + 10'd1) > 10'd23) ||
                (op_e'(op_q) == OP_LENGTH && lz_w > 6'd12)) begin
              val_d = '0; stat_d = StatusInvalid; state_d = S_DONE;
            end
          end
          OP_FLUFF: begin
            if (arg_q == 9'd256) begin
              val_d = '0; state_d = S_DONE;
            end
          end
          default: ;
        endcase
      end
      S_TAKE: begin
        state_d = S_DONE;
        unique case (op_e'(op_q))
          OP_RAW: begin
            if (arg_q <= 9'd24) begin
              tk_n = 6'(arg_q); val_d = tk_val;
            end else if (phase_q == 2'd0) begin
              tk_n = 6'd24; acc_d = tk_val << (arg_q - 9'd24);
              phase_d = 2'd1; state_d = S_FILL;
            end else begin
              tk_n = 6'(arg_q - 9'd24); val_d = acc_q + tk_val;
            end
          end
          OP_GAMMA: begin
            tk_n = {lz_q[4:0], 1'b0} + 6'd2; val_d = tk_val - 32'd2;
          end
          OP_FGAMMA: begin
            tk_n = lz_q + 6'(arg_q) + 6'd1;
            val_d = tk_val + ((32'(lz_q) - 32'd1) << arg_q);
          end
          OP_LENGTH: begin
            if (phase_q == 2'd0) begin
              tk_n = lz_q; phase_d = 2'd1; state_d = S_FILL;
            end else begin
              tk_n = lz_q + 6'd7; val_d = tk_val - LengthBias;
            end
          end
          OP_OFFSET: begin
            if (phase_q == 2'd0) begin
              tk_n = n_off;
              if (arg_q < 9'h0F0) begin
                val_d = ((((32'd1 << n_off) | tk_val) << 4) + 32'(arg_q[3:0]))
                        - OffsetBias;
              end else begin
                acc_d = OffsetBigBase + (((32'd1 << n_off) | tk_val) << 12);
                phase_d = 2'd1; state_d = S_FILL;
              end
            end else begin
              tk_n = 6'd12; val_d = acc_q + tk_val;
            end
          end
          default: begin
            if ((fv >> 1) >= fz) begin
              tk_n = fy; val_d = fv - fz;
            end else begin
              tk_n = fy - 6'd1; val_d = fv >> 1;
            end
          end
        endcase
        win_d = tk_win;
        def_d = def_q + 7'(tk_n);
        if (state_d == S_DONE) stat_d = starve_q ? StatusUnderflow : StatusOk;
      end
      S_DONE: begin
        // Hold until the result register is free
        if (!oval_q || out_ready_i) begin
          oval_d = 1'b1; rval_d = val_q; rstat_d = stat_q; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; win_q <= '0; def_q <= 7'sd24; end_q <= 1'b0;
      starve_q <= 1'b0; oval_q <= 1'b0; phase_q <= '0;
      rval_q <= '0; rstat_q <= StatusOk;
    end else begin
      state_q <= state_d; win_q <= win_d; def_q <= def_d; end_q <= end_d;
      starve_q <= starve_d; oval_q <= oval_d; phase_q <= phase_d;
      rval_q <= rval_d; rstat_q <= rstat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_d_hold: begin
      op_q <= op_d; arg_q <= arg_d; acc_q <= acc_d; lz_q <= lz_d;
      val_q <= val_d; stat_q <= stat_d;
    end
  end

  assign out_valid_o = oval_q;
  assign value_o     = rval_q;
  assign status_o    = rstat_q;

endmodule
